@@ hw/rtl/mesh_vertex_skinning_defines.svh @@
// assertion macros for the skinning block controller (mvs_ctrl)
// used by files that include this header; expects clk and rst_n in scope
`ifndef MESH_VERTEX_SKINNING_DEFINES_SVH
`define MESH_VERTEX_SKINNING_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MVS_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MVS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mvs_pkg.sv @@
// shared types, codes and saturation helpers for the skinning block
// no dependencies; used by mvs_datapath, mvs_ctrl and mesh_vertex_skinning
package mvs_pkg;

    // default sizing
    localparam int MAX_BONES_DEF = 64;
    localparam int FRAC_BITS_DEF = 16;

    // fixed field widths
    localparam int NUM_COEF   = 6;
    localparam int COORD_W    = 32;
    localparam int WEIGHT_W   = 17;
    localparam int DEPTH_W    = 16;
    localparam int SCALE_W    = 31;
    localparam int BONE_W     = 6;
    localparam int CIDX_W     = 3;
    localparam int ACC_W      = 48;
    localparam int PROD_W     = 64;
    localparam int WPROD_W    = COORD_W + WEIGHT_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    // coefficient slots within one bone
    localparam int COEF_A  = 0;
    localparam int COEF_B  = 1;
    localparam int COEF_C  = 2;
    localparam int COEF_D  = 3;
    localparam int COEF_TX = 4;
    localparam int COEF_TY = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFORM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 2'd2;

    // item kinds
    typedef enum logic [1:0] {
        MODE_LOAD     = 2'd0,
        MODE_WEIGHTED = 2'd1,
        MODE_PLAIN    = 2'd2
    } mode_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic load;
        logic scale;
        logic move;
        logic xform;
        logic sum;
        logic weight;
        logic acc;
        logic emit;
        logic plain;
    } mvs_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic bone_ok;
        logic out_free;
    } mvs_status_t;

    // clamp to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < 64'shFFFF_FFFF_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    // clamp to signed 48 bits
    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        logic signed [47:0] r;
        if (v > 64'sh0000_7FFF_FFFF_FFFF)
            r = 48'sh7FFF_FFFF_FFFF;
        else if (v < 64'shFFFF_8000_0000_0000)
            r = 48'sh8000_0000_0000;
        else
            r = v[47:0];
        return r;
    endfunction

endpackage

@@ hw/rtl/mvs_datapath.sv @@
// skinning datapath: config registers, banked bone table, multiply chain,
// accumulators and output register; depends on mvs_pkg
module mvs_datapath #(
    parameter int MAX_BONES = mvs_pkg::MAX_BONES_DEF,
    parameter int FRAC_BITS = mvs_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  mvs_pkg::mvs_cmd_t                    cmd,
    output mvs_pkg::mvs_status_t                 status,
    input  logic                                 cfg_write,
    input  logic [mvs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mvs_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [mvs_pkg::BONE_W-1:0]           bone_index,
    input  logic [mvs_pkg::CIDX_W-1:0]           coef_index,
    input  logic signed [mvs_pkg::COORD_W-1:0]   coef_value,
    input  logic [mvs_pkg::WEIGHT_W-1:0]         weight,
    input  logic signed [mvs_pkg::COORD_W-1:0]   local_x,
    input  logic signed [mvs_pkg::COORD_W-1:0]   local_y,
    input  logic signed [mvs_pkg::COORD_W-1:0]   deform_x,
    input  logic signed [mvs_pkg::COORD_W-1:0]   deform_y,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [mvs_pkg::COORD_W-1:0]   pos_x,
    output logic signed [mvs_pkg::COORD_W-1:0]   pos_y,
    output logic signed [mvs_pkg::DEPTH_W-1:0]   pos_z
);

    localparam int BAW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

    // configuration registers
    logic [mvs_pkg::SCALE_W-1:0]        scale_reg;
    logic                               deform_en_reg;
    logic signed [mvs_pkg::DEPTH_W-1:0] depth_reg;

    // captured item
    logic [BAW-1:0]                     bone_reg;
    logic [mvs_pkg::WEIGHT_W-1:0]       weight_reg;
    logic signed [mvs_pkg::COORD_W-1:0] lx_reg;
    logic signed [mvs_pkg::COORD_W-1:0] ly_reg;
    logic signed [mvs_pkg::COORD_W-1:0] dx_reg;
    logic signed [mvs_pkg::COORD_W-1:0] dy_reg;

    // pipeline of the multiply chain
    logic signed [mvs_pkg::PROD_W-1:0]  scl_x_reg;
    logic signed [mvs_pkg::PROD_W-1:0]  scl_y_reg;
    logic signed [mvs_pkg::COORD_W-1:0] x_reg;
    logic signed [mvs_pkg::COORD_W-1:0] y_reg;
    logic signed [mvs_pkg::PROD_W-1:0]  pa_reg;
    logic signed [mvs_pkg::PROD_W-1:0]  pb_reg;
    logic signed [mvs_pkg::PROD_W-1:0]  pc_reg;
    logic signed [mvs_pkg::PROD_W-1:0]  pd_reg;
    logic signed [mvs_pkg::COORD_W-1:0] gx_reg;
    logic signed [mvs_pkg::COORD_W-1:0] gy_reg;
    logic signed [mvs_pkg::WPROD_W-1:0] wx_reg;
    logic signed [mvs_pkg::WPROD_W-1:0] wy_reg;
    logic signed [mvs_pkg::ACC_W-1:0]   acc_x_reg;
    logic signed [mvs_pkg::ACC_W-1:0]   acc_y_reg;

    // output register
    logic                               out_valid_reg;
    logic signed [mvs_pkg::COORD_W-1:0] pos_x_reg;
    logic signed [mvs_pkg::COORD_W-1:0] pos_y_reg;
    logic signed [mvs_pkg::DEPTH_W-1:0] pos_z_reg;

    // combinational step results
    logic                               bone_ok;
    logic                               add_deform;
    logic signed [mvs_pkg::COORD_W-1:0] sx;
    logic signed [mvs_pkg::COORD_W-1:0] sy;
    logic signed [mvs_pkg::COORD_W-1:0] mx;
    logic signed [mvs_pkg::COORD_W-1:0] my;
    logic signed [mvs_pkg::COORD_W-1:0] gx;
    logic signed [mvs_pkg::COORD_W-1:0] gy;
    logic signed [mvs_pkg::ACC_W-1:0]   ax;
    logic signed [mvs_pkg::ACC_W-1:0]   ay;
    logic signed [mvs_pkg::COORD_W-1:0] coef_rd [mvs_pkg::NUM_COEF];

    // bone range check on the incoming index
    assign bone_ok = 32'(bone_index) < MAX_BONES;

    assign status.bone_ok  = bone_ok;
    assign status.out_free = !out_valid_reg || out_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= mvs_pkg::SCALE_W'(1) << FRAC_BITS;
            deform_en_reg <= 1'b0;
            depth_reg     <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mvs_pkg::CFG_SCALE:  scale_reg     <= cfg_data;
                mvs_pkg::CFG_DEFORM: deform_en_reg <= cfg_data[0];
                mvs_pkg::CFG_DEPTH:  depth_reg     <= cfg_data[mvs_pkg::DEPTH_W-1:0];
                default:             ;
            endcase
        end
    end

    // bone table: one bank per coefficient, one write and one registered read each
    for (genvar k = 0; k < mvs_pkg::NUM_COEF; k++)
    begin : g_bank
        logic [mvs_pkg::COORD_W-1:0] mem [MAX_BONES];
        logic [mvs_pkg::COORD_W-1:0] rd_reg;

        always_ff @(posedge clk)
        begin
            if (cmd.load && bone_ok && coef_index == mvs_pkg::CIDX_W'(k))
                mem[BAW'(bone_index)] <= coef_value;
            rd_reg <= mem[bone_reg];
        end

        assign coef_rd[k] = rd_reg;
    end

    // capture the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            bone_reg   <= BAW'(bone_index);
            weight_reg <= weight;
            lx_reg     <= local_x;
            ly_reg     <= local_y;
            dx_reg     <= deform_x;
            dy_reg     <= deform_y;
        end
    end

    // scale, offset, transform and accumulate steps
    always_comb
    begin
        add_deform = cmd.plain || deform_en_reg;
        sx = mvs_pkg::sat32(scl_x_reg >>> FRAC_BITS);
        sy = mvs_pkg::sat32(scl_y_reg >>> FRAC_BITS);
        mx = mvs_pkg::sat32(64'(sx) + (add_deform ? 64'(dx_reg) : 64'sd0));
        my = mvs_pkg::sat32(64'(sy) + (add_deform ? 64'(dy_reg) : 64'sd0));
        gx = mvs_pkg::sat32((pa_reg >>> FRAC_BITS) + (pc_reg >>> FRAC_BITS)
                            + 64'(coef_rd[mvs_pkg::COEF_TX]));
        gy = mvs_pkg::sat32((pb_reg >>> FRAC_BITS) + (pd_reg >>> FRAC_BITS)
                            + 64'(coef_rd[mvs_pkg::COEF_TY]));
        ax = mvs_pkg::sat48(64'(acc_x_reg) + 64'(wx_reg >>> FRAC_BITS));
        ay = mvs_pkg::sat48(64'(acc_y_reg) + 64'(wy_reg >>> FRAC_BITS));
    end

    // multiply chain registers
    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            scl_x_reg <= lx_reg * $signed({1'b0, scale_reg});
            scl_y_reg <= ly_reg * $signed({1'b0, scale_reg});
        end
        if (cmd.move)
        begin
            x_reg <= mx;
            y_reg <= my;
        end
        if (cmd.xform)
        begin
            pa_reg <= coef_rd[mvs_pkg::COEF_A] * x_reg;
            pc_reg <= coef_rd[mvs_pkg::COEF_C] * y_reg;
            pb_reg <= coef_rd[mvs_pkg::COEF_B] * x_reg;
            pd_reg <= coef_rd[mvs_pkg::COEF_D] * y_reg;
        end
        if (cmd.sum)
        begin
            gx_reg <= gx;
            gy_reg <= gy;
        end
        if (cmd.weight)
        begin
            wx_reg <= gx_reg * $signed({1'b0, weight_reg});
            wy_reg <= gy_reg * $signed({1'b0, weight_reg});
        end
    end

    // accumulators, cleared when a weighted vertex is emitted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end
        else if (cmd.acc)
        begin
            acc_x_reg <= ax;
            acc_y_reg <= ay;
        end
        else if (cmd.emit && !cmd.plain)
        begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end
    end

    // output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (cmd.plain)
            begin
                pos_x_reg <= x_reg;
                pos_y_reg <= y_reg;
                pos_z_reg <= '0;
            end
            else
            begin
                pos_x_reg <= mvs_pkg::sat32(64'(acc_x_reg));
                pos_y_reg <= mvs_pkg::sat32(64'(acc_y_reg));
                pos_z_reg <= depth_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pos_z     = pos_z_reg;

endmodule

@@ hw/rtl/mvs_ctrl.sv @@
// skinning controller: sequences loads, influences and plain vertices
// depends on mvs_pkg and mesh_vertex_skinning_defines.svh
`include "mesh_vertex_skinning_defines.svh"

module mvs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           mode,
    input  logic                 bone_present,
    input  logic                 last_influence,
    input  mvs_pkg::mvs_status_t status,
    output mvs_pkg::mvs_cmd_t    cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SCALE  = 8'b0000_0010,
        S_MOVE   = 8'b0000_0100,
        S_XFORM  = 8'b0000_1000,
        S_SUM    = 8'b0001_0000,
        S_WEIGHT = 8'b0010_0000,
        S_ACC    = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   plain_reg;
    logic   plain_next;
    logic   last_reg;
    logic   last_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        plain_next = plain_reg;
        last_next  = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (mode)
                        mvs_pkg::MODE_WEIGHTED:
                        begin
                            plain_next = 1'b0;
                            last_next  = last_influence;
                            if (bone_present && status.bone_ok)
                                state_next = S_SCALE;
                            else if (last_influence)
                                state_next = S_EMIT;
                        end
                        mvs_pkg::MODE_PLAIN:
                        begin
                            plain_next = 1'b1;
                            last_next  = 1'b1;
                            state_next = S_SCALE;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCALE:  state_next = S_MOVE;
            S_MOVE:   state_next = plain_reg ? S_EMIT : S_XFORM;
            S_XFORM:  state_next = S_SUM;
            S_SUM:    state_next = S_WEIGHT;
            S_WEIGHT: state_next = S_ACC;
            S_ACC:    state_next = last_reg ? S_EMIT : S_IDLE;
            S_EMIT:
            begin
                if (status.out_free)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            plain_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            plain_reg <= plain_next;
            last_reg  <= last_next;
        end
    end

    // datapath commands
    always_comb
    begin
        cmd.capture = accept;
        cmd.load    = accept && (mode == mvs_pkg::MODE_LOAD);
        cmd.scale   = (state_reg == S_SCALE);
        cmd.move    = (state_reg == S_MOVE);
        cmd.xform   = (state_reg == S_XFORM);
        cmd.sum     = (state_reg == S_SUM);
        cmd.weight  = (state_reg == S_WEIGHT);
        cmd.acc     = (state_reg == S_ACC);
        cmd.emit    = (state_reg == S_EMIT) && status.out_free;
        cmd.plain   = plain_reg;
    end

    // checks
    `MVS_ASSERT_IMPL(a_emit_slot_free, cmd.emit, status.out_free, "emit into full output")
    `MVS_ASSERT_NEXT(a_scale_then_move, state_reg == S_SCALE, state_reg == S_MOVE, "no move")
    `MVS_ASSERT_NEXT(a_load_one_cycle, cmd.load, in_ready, "load did not return to ready")
    `MVS_ASSERT_NEXT(a_acc_no_last, state_reg == S_ACC && !last_reg, in_ready, "inner stall")

endmodule

@@ hw/rtl/mesh_vertex_skinning.sv @@
// 2D linear blend skinning with a Q16.16 affine bone table.
// Input channel in_valid/in_ready carries one word per item: a coefficient
// load (mode 0), one weighted bone influence (mode 1) or a plain deform
// vertex (mode 2). Output channel out_valid/out_ready carries pos_x/y/z.
// Configuration uses cfg_write/cfg_index/cfg_data, taken at any edge with
// cfg_write high; write it only while the block is idle.
// Controller steps per item, set by the chain of registered multiplies:
//   load or unused mode: idle step only; absent bone: emit if last
//   weighted influence: scale, move, xform, sum, weight, acc; emit if last
//   plain deform: scale, move, emit
// in_ready is high only between items; a stalled receiver holds the final emit
// step, and the next item is taken the cycle after the waiting word is accepted.
// Reset clears the accumulators and config (scale one, deform off, depth zero);
// the bone table is not cleared and must be loaded before use.
// Depends on mvs_pkg, mvs_ctrl and mvs_datapath.
module mesh_vertex_skinning #(
    parameter int MAX_BONES = mvs_pkg::MAX_BONES_DEF,
    parameter int FRAC_BITS = mvs_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [mvs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mvs_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           mode,
    input  logic [mvs_pkg::BONE_W-1:0]           bone_index,
    input  logic [mvs_pkg::CIDX_W-1:0]           coef_index,
    input  logic signed [mvs_pkg::COORD_W-1:0]   coef_value,
    input  logic                                 bone_present,
    input  logic [mvs_pkg::WEIGHT_W-1:0]         weight,
    input  logic signed [mvs_pkg::COORD_W-1:0]   local_x,
    input  logic signed [mvs_pkg::COORD_W-1:0]   local_y,
    input  logic signed [mvs_pkg::COORD_W-1:0]   deform_x,
    input  logic signed [mvs_pkg::COORD_W-1:0]   deform_y,
    input  logic                                 last_influence,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [mvs_pkg::COORD_W-1:0]   pos_x,
    output logic signed [mvs_pkg::COORD_W-1:0]   pos_y,
    output logic signed [mvs_pkg::DEPTH_W-1:0]   pos_z
);

    mvs_pkg::mvs_cmd_t    cmd;
    mvs_pkg::mvs_status_t status;

    // sequencer
    mvs_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .bone_present   (bone_present),
        .last_influence (last_influence),
        .status         (status),
        .cmd            (cmd)
    );

    // arithmetic, bone table and output register
    mvs_datapath #(
        .MAX_BONES (MAX_BONES),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .bone_index (bone_index),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .weight     (weight),
        .local_x    (local_x),
        .local_y    (local_y),
        .deform_x   (deform_x),
        .deform_y   (deform_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z)
    );

endmodule

@@ sim/tb_mesh_vertex_skinning.sv @@
// self-checking testbench for mesh_vertex_skinning: directed table, then random skinning traffic
// carries its own fixed-point skinning predictor; depends on mvs_pkg and the block's rtl
module tb_mesh_vertex_skinning;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam int         SETTLE_CYCLES = 20;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         PHASE_WORDS   = 220;
    localparam int         NUM_PHASES    = 8;
    localparam longint     S32_MAX       = 64'sh0000_0000_7FFF_FFFF;
    localparam longint     S32_MIN       = -S32_MAX - 1;
    localparam longint     S48_MAX       = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint     S48_MIN       = -S48_MAX - 1;
    localparam int         TABLE_WORDS   = mvs_pkg::MAX_BONES_DEF * mvs_pkg::NUM_COEF;

    // one input word
    typedef struct {
        logic [1:0]                         mode;
        logic [mvs_pkg::BONE_W-1:0]         bone;
        logic [mvs_pkg::CIDX_W-1:0]         cidx;
        logic signed [mvs_pkg::COORD_W-1:0] cval;
        logic                               present;
        logic [mvs_pkg::WEIGHT_W-1:0]       wt;
        logic signed [mvs_pkg::COORD_W-1:0] lx;
        logic signed [mvs_pkg::COORD_W-1:0] ly;
        logic signed [mvs_pkg::COORD_W-1:0] dx;
        logic signed [mvs_pkg::COORD_W-1:0] dy;
        logic                               last;
    } skin_word_t;

    // one output position
    typedef struct {
        logic signed [mvs_pkg::COORD_W-1:0] x;
        logic signed [mvs_pkg::COORD_W-1:0] y;
        logic signed [mvs_pkg::DEPTH_W-1:0] z;
    } vtx_pos_t;

    // directed table row: either a register write or an input word
    typedef struct {
        bit                            is_cfg;
        logic [mvs_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [mvs_pkg::SCALE_W-1:0]   reg_val;
        skin_word_t                    w;
        bit                            typed;
        vtx_pos_t                      typed_pos;
    } dir_row_t;

    logic                               clk            = 1'b0;
    logic                               rst_n          = 1'b0;
    logic                               cfg_write      = 1'b0;
    logic [mvs_pkg::CFG_IDX_W-1:0]      cfg_index      = '0;
    logic [mvs_pkg::CFG_DATA_W-1:0]     cfg_data       = '0;
    logic                               in_valid       = 1'b0;
    logic                               in_ready;
    logic [1:0]                         mode           = '0;
    logic [mvs_pkg::BONE_W-1:0]         bone_index     = '0;
    logic [mvs_pkg::CIDX_W-1:0]         coef_index     = '0;
    logic signed [mvs_pkg::COORD_W-1:0] coef_value     = '0;
    logic                               bone_present   = 1'b0;
    logic [mvs_pkg::WEIGHT_W-1:0]       weight         = '0;
    logic signed [mvs_pkg::COORD_W-1:0] local_x        = '0;
    logic signed [mvs_pkg::COORD_W-1:0] local_y        = '0;
    logic signed [mvs_pkg::COORD_W-1:0] deform_x       = '0;
    logic signed [mvs_pkg::COORD_W-1:0] deform_y       = '0;
    logic                               last_influence = 1'b0;
    logic                               out_valid;
    logic                               out_ready      = 1'b0;
    logic signed [mvs_pkg::COORD_W-1:0] pos_x;
    logic signed [mvs_pkg::COORD_W-1:0] pos_y;
    logic signed [mvs_pkg::DEPTH_W-1:0] pos_z;

    // predictor state
    logic signed [mvs_pkg::COORD_W-1:0] bone_coef [TABLE_WORDS];
    bit                                 coef_known [TABLE_WORDS];
    longint                             acc_x    = 0;
    longint                             acc_y    = 0;
    logic [mvs_pkg::SCALE_W-1:0]        scale_q  = 31'd65536;
    logic                               deform_q = 1'b0;
    logic signed [mvs_pkg::DEPTH_W-1:0] depth_q  = '0;

    vtx_pos_t   pending_pos [$];
    dir_row_t   dir_rows [$];
    int         err_count     = 0;
    int         words_sent    = 0;
    int         send_idle_pct = 0;
    int         stall_pct     = 0;
    int         cycle_count   = 0;

    mesh_vertex_skinning dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .bone_index     (bone_index),
        .coef_index     (coef_index),
        .coef_value     (coef_value),
        .bone_present   (bone_present),
        .weight         (weight),
        .local_x        (local_x),
        .local_y        (local_y),
        .deform_x       (deform_x),
        .deform_y       (deform_y),
        .last_influence (last_influence),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z)
    );

    // clock
    always #6 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver backpressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // compare each output word with the oldest predicted position
    always @(posedge clk)
    begin : check_out
        vtx_pos_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pos.size() == 0)
            begin
                $error("output word with no expected position: x=%0d y=%0d z=%0d",
                       pos_x, pos_y, pos_z);
                err_count++;
            end
            else
            begin
                want = pending_pos.pop_front();
                if (pos_x !== want.x)
                begin
                    $error("pos_x mismatch: expected %0d, got %0d", want.x, pos_x);
                    err_count++;
                end
                if (pos_y !== want.y)
                begin
                    $error("pos_y mismatch: expected %0d, got %0d", want.y, pos_y);
                    err_count++;
                end
                if (pos_z !== want.z)
                begin
                    $error("pos_z mismatch: expected %0d, got %0d", want.z, pos_z);
                    err_count++;
                end
            end
        end
    end

    function automatic longint clamp64(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // local coordinate times armature scale, floored and saturated
    function automatic longint scale_local(input logic signed [mvs_pkg::COORD_W-1:0] v);
        return clamp64((longint'(v) * longint'(scale_q)) >>> mvs_pkg::FRAC_BITS_DEF,
                       S32_MIN, S32_MAX);
    endfunction

    // product floored by the fraction bits
    function automatic longint fshift(input longint v);
        return v >>> mvs_pkg::FRAC_BITS_DEF;
    endfunction

    function automatic longint coef_of(input int bone, input int slot);
        return longint'(bone_coef[bone * mvs_pkg::NUM_COEF + slot]);
    endfunction

    function automatic bit bone_loaded(input int bone);
        for (int k = 0; k < mvs_pkg::NUM_COEF; k++)
            if (!coef_known[bone * mvs_pkg::NUM_COEF + k])
                return 1'b0;
        return 1'b1;
    endfunction

    // skinning predictor: updates table and accumulators, returns 1 when a position is due
    function automatic bit skin_step(input skin_word_t w, output vtx_pos_t pos);
        longint sx, sy, gx, gy;
        int     bone;
        pos  = '{x: '0, y: '0, z: '0};
        bone = int'(w.bone);
        if (w.mode == mvs_pkg::MODE_LOAD)
        begin
            if (bone < mvs_pkg::MAX_BONES_DEF && w.cidx < mvs_pkg::NUM_COEF)
            begin
                bone_coef[bone * mvs_pkg::NUM_COEF + w.cidx]  = w.cval;
                coef_known[bone * mvs_pkg::NUM_COEF + w.cidx] = 1'b1;
            end
            return 1'b0;
        end
        // plain deform always adds the offsets and leaves the accumulators alone
        if (w.mode == mvs_pkg::MODE_PLAIN)
        begin
            pos.x = mvs_pkg::COORD_W'(clamp64(scale_local(w.lx) + longint'(w.dx),
                                              S32_MIN, S32_MAX));
            pos.y = mvs_pkg::COORD_W'(clamp64(scale_local(w.ly) + longint'(w.dy),
                                              S32_MIN, S32_MAX));
            return 1'b1;
        end
        if (w.mode != mvs_pkg::MODE_WEIGHTED)
            return 1'b0;
        // absent bone contributes nothing
        if (w.present && bone < mvs_pkg::MAX_BONES_DEF)
        begin
            sx = scale_local(w.lx);
            sy = scale_local(w.ly);
            if (deform_q)
            begin
                sx = clamp64(sx + longint'(w.dx), S32_MIN, S32_MAX);
                sy = clamp64(sy + longint'(w.dy), S32_MIN, S32_MAX);
            end
            gx = fshift(coef_of(bone, mvs_pkg::COEF_A) * sx)
               + fshift(coef_of(bone, mvs_pkg::COEF_C) * sy) + coef_of(bone, mvs_pkg::COEF_TX);
            gy = fshift(coef_of(bone, mvs_pkg::COEF_B) * sx)
               + fshift(coef_of(bone, mvs_pkg::COEF_D) * sy) + coef_of(bone, mvs_pkg::COEF_TY);
            gx = clamp64(gx, S32_MIN, S32_MAX);
            gy = clamp64(gy, S32_MIN, S32_MAX);
            acc_x = clamp64(acc_x + fshift(gx * longint'(w.wt)), S48_MIN, S48_MAX);
            acc_y = clamp64(acc_y + fshift(gy * longint'(w.wt)), S48_MIN, S48_MAX);
        end
        if (!w.last)
            return 1'b0;
        pos.x = mvs_pkg::COORD_W'(clamp64(acc_x, S32_MIN, S32_MAX));
        pos.y = mvs_pkg::COORD_W'(clamp64(acc_y, S32_MIN, S32_MAX));
        pos.z = depth_q;
        acc_x = 0;
        acc_y = 0;
        return 1'b1;
    endfunction

    // word builders
    function automatic skin_word_t load_w(input int bone, input int cidx,
                                          input logic signed [mvs_pkg::COORD_W-1:0] val);
        skin_word_t w;
        w = '{default: '0};
        w.mode = mvs_pkg::MODE_LOAD;
        w.bone = mvs_pkg::BONE_W'(bone);
        w.cidx = mvs_pkg::CIDX_W'(cidx);
        w.cval = val;
        return w;
    endfunction

    function automatic skin_word_t infl_w(input int bone, input bit present,
                                          input logic [mvs_pkg::WEIGHT_W-1:0] wt,
                                          input logic signed [mvs_pkg::COORD_W-1:0] lx, ly,
                                          input logic signed [mvs_pkg::COORD_W-1:0] dx, dy,
                                          input bit last);
        skin_word_t w;
        w = '{default: '0};
        w.mode    = mvs_pkg::MODE_WEIGHTED;
        w.bone    = mvs_pkg::BONE_W'(bone);
        w.present = present;
        w.wt      = wt;
        w.lx      = lx;
        w.ly      = ly;
        w.dx      = dx;
        w.dy      = dy;
        w.last    = last;
        return w;
    endfunction

    function automatic skin_word_t plain_w(input logic signed [mvs_pkg::COORD_W-1:0] lx, ly,
                                           input logic signed [mvs_pkg::COORD_W-1:0] dx, dy);
        skin_word_t w;
        w = '{default: '0};
        w.mode = mvs_pkg::MODE_PLAIN;
        w.lx   = lx;
        w.ly   = ly;
        w.dx   = dx;
        w.dy   = dy;
        return w;
    endfunction

    // random field values, biased toward extremes
    function automatic logic signed [mvs_pkg::COORD_W-1:0] rand_coord();
        case ($urandom_range(9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3, 4:    return $urandom;
            default: return $signed($urandom_range(32'h0080_0000)) - 32'sh0040_0000;
        endcase
    endfunction

    function automatic logic signed [mvs_pkg::COORD_W-1:0] rand_coef();
        case ($urandom_range(7))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return $urandom;
            default: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    function automatic logic [mvs_pkg::WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(9))
            0:       return '0;
            1:       return 17'd65536;
            2:       return mvs_pkg::WEIGHT_W'($urandom_range(65537, 131071));
            default: return mvs_pkg::WEIGHT_W'($urandom_range(65536));
        endcase
    endfunction

    // a bone with all six coefficients known, or bone 0 which the directed part loads
    function automatic int pick_bone();
        int b;
        for (int t = 0; t < 8; t++)
        begin
            b = $urandom_range(mvs_pkg::MAX_BONES_DEF - 1);
            if (bone_loaded(b))
                return b;
        end
        return 0;
    endfunction

    // directed table builders
    task automatic add_word(input skin_word_t w);
        dir_row_t r;
        r = '{default: '0};
        r.w = w;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic add_typed(input skin_word_t w,
                             input logic signed [mvs_pkg::COORD_W-1:0] x, y,
                             input logic signed [mvs_pkg::DEPTH_W-1:0] z);
        dir_row_t r;
        r = '{default: '0};
        r.w         = w;
        r.typed     = 1'b1;
        r.typed_pos = '{x: x, y: y, z: z};
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic add_cfg(input logic [mvs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mvs_pkg::SCALE_W-1:0] val);
        dir_row_t r;
        r = '{default: '0};
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    // present one word, hold it until taken, then predict its result
    task automatic send_word(input skin_word_t w, input bit typed, input vtx_pos_t typed_pos);
        vtx_pos_t pos;
        bit       has_pos;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        mode           <= w.mode;
        bone_index     <= w.bone;
        coef_index     <= w.cidx;
        coef_value     <= w.cval;
        bone_present   <= w.present;
        weight         <= w.wt;
        local_x        <= w.lx;
        local_y        <= w.ly;
        deform_x       <= w.dx;
        deform_y       <= w.dy;
        last_influence <= w.last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        has_pos = skin_step(w, pos);
        if (typed)
            pending_pos.insert(pending_pos.size(), typed_pos);
        else if (has_pos)
            pending_pos.insert(pending_pos.size(), pos);
        if (w.mode != MODE_UNUSED)
            words_sent++;
    endtask

    task automatic send_plain(input skin_word_t w);
        send_word(w, 1'b0, '{x: '0, y: '0, z: '0});
    endtask

    // wait for every expected word, then let the pipeline run dry
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_pos.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mvs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mvs_pkg::SCALE_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        case (idx)
            mvs_pkg::CFG_SCALE:  scale_q  = val;
            mvs_pkg::CFG_DEFORM: deform_q = val[0];
            mvs_pkg::CFG_DEPTH:  depth_q  = val[mvs_pkg::DEPTH_W-1:0];
            default:             ;
        endcase
    endtask

    // stimulus
    initial
    begin : stim
        skin_word_t w;
        int         target;
        int         pick;
        int         nin;
        int         b;

        foreach (bone_coef[i])
        begin
            bone_coef[i]  = '0;
            coef_known[i] = 1'b0;
        end

        // directed table
        add_typed(infl_w(5, 1'b0, 17'd65536, 32'sd65536, 32'sd65536, '0, '0, 1'b1),
                  32'sd0, 32'sd0, 16'sd0);
        add_typed(plain_w(32'sd65536, -32'sd65536, 32'sd65536, '0),
                  32'sd131072, -32'sd65536, 16'sd0);
        add_typed(plain_w(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000),
                  32'sh7FFF_FFFF, 32'sh8000_0000, 16'sd0);
        w = infl_w(9, 1'b1, 17'h1FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, '1, '1, 1'b1);
        w.mode = MODE_UNUSED;
        add_word(w);
        // identity bone with a translation
        add_word(load_w(0, mvs_pkg::COEF_A, 32'sd65536));
        add_word(load_w(0, mvs_pkg::COEF_B, '0));
        add_word(load_w(0, mvs_pkg::COEF_C, '0));
        add_word(load_w(0, mvs_pkg::COEF_D, 32'sd65536));
        add_word(load_w(0, mvs_pkg::COEF_TX, 32'sd131072));
        add_word(load_w(0, mvs_pkg::COEF_TY, -32'sd196608));
        // coefficient slot out of range is dropped
        add_word(load_w(0, mvs_pkg::NUM_COEF, 32'sh7FFF_FFFF));
        add_typed(infl_w(0, 1'b1, 17'd65536, 32'sd65536, 32'sd65536, '0, '0, 1'b1),
                  32'sd196608, -32'sd131072, 16'sd0);
        // bone at the top of the table with extreme coefficients
        add_word(load_w(63, mvs_pkg::COEF_A, 32'sh7FFF_FFFF));
        add_word(load_w(63, mvs_pkg::COEF_B, 32'sh8000_0000));
        add_word(load_w(63, mvs_pkg::COEF_C, 32'sh7FFF_FFFF));
        add_word(load_w(63, mvs_pkg::COEF_D, 32'sh8000_0000));
        add_word(load_w(63, mvs_pkg::COEF_TX, 32'sh7FFF_FFFF));
        add_word(load_w(63, mvs_pkg::COEF_TY, 32'sh8000_0000));
        // weight above one, then an absent bone that still closes the vertex
        add_word(infl_w(63, 1'b1, 17'h1FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, '0, '0, 1'b0));
        add_word(infl_w(63, 1'b0, 17'd65536, 32'sd65536, 32'sd65536, '0, '0, 1'b1));
        // register extremes with deform on
        add_cfg(mvs_pkg::CFG_DEPTH, 31'h0000_8000);
        add_cfg(mvs_pkg::CFG_DEFORM, 31'd1);
        add_cfg(mvs_pkg::CFG_SCALE, 31'h7FFF_FFFF);
        add_word(infl_w(0, 1'b1, 17'd65536, 32'sh7FFF_FFFF, -32'sd7, 32'sh7FFF_FFFF, '0, 1'b1));
        add_cfg(mvs_pkg::CFG_SCALE, '0);
        add_typed(plain_w(32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1, 32'sd5),
                  -32'sd1, 32'sd5, 16'sd0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
            begin
                settle();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end
            else
                send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].typed_pos);
        end

        // random phases, each with a register setting and an idle pattern chosen for it
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            case (ph)
                0:       write_reg(mvs_pkg::CFG_SCALE, 31'd65536);
                1:       write_reg(mvs_pkg::CFG_SCALE, 31'd32768);
                2:       write_reg(mvs_pkg::CFG_SCALE, 31'h7FFF_FFFF);
                3:       write_reg(mvs_pkg::CFG_SCALE, '0);
                4:       write_reg(mvs_pkg::CFG_SCALE,
                                   mvs_pkg::SCALE_W'($urandom_range(262144)));
                5:       write_reg(mvs_pkg::CFG_SCALE, 31'd131072);
                6:       write_reg(mvs_pkg::CFG_SCALE,
                                   mvs_pkg::SCALE_W'($urandom_range(32'h7FFF_FFFF)));
                default: write_reg(mvs_pkg::CFG_SCALE, 31'd65536);
            endcase
            write_reg(mvs_pkg::CFG_DEFORM, mvs_pkg::SCALE_W'(ph % 2));
            case (ph)
                0:       write_reg(mvs_pkg::CFG_DEPTH, '0);
                1:       write_reg(mvs_pkg::CFG_DEPTH, 31'h0000_7FFF);
                2:       write_reg(mvs_pkg::CFG_DEPTH, 31'h0000_8000);
                default: write_reg(mvs_pkg::CFG_DEPTH,
                                   mvs_pkg::SCALE_W'($urandom_range(65535)));
            endcase
            case (ph % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 71; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 71; end
                default: begin send_idle_pct = 23; stall_pct = 23; end
            endcase

            target = words_sent + PHASE_WORDS;
            while (words_sent < target)
            begin
                pick = $urandom_range(99);
                if (pick < 10)
                begin
                    // reload a whole bone
                    b = $urandom_range(mvs_pkg::MAX_BONES_DEF - 1);
                    for (int k = 0; k < mvs_pkg::NUM_COEF; k++)
                        send_plain(load_w(b, k, rand_coef()));
                end
                else if (pick < 13)
                    send_plain(load_w($urandom_range(mvs_pkg::MAX_BONES_DEF - 1),
                                      $urandom_range(7), rand_coef()));
                else if (pick < 23)
                    send_plain(plain_w(rand_coord(), rand_coord(), rand_coord(), rand_coord()));
                else if (pick < 26)
                begin
                    w = infl_w($urandom_range(63), 1'($urandom_range(1)),
                               mvs_pkg::WEIGHT_W'($urandom), $urandom, $urandom, $urandom,
                               $urandom, 1'($urandom_range(1)));
                    w.mode = MODE_UNUSED;
                    w.cidx = mvs_pkg::CIDX_W'($urandom_range(7));
                    w.cval = $urandom;
                    send_plain(w);
                end
                else
                begin
                    // one vertex of one to four influences
                    nin = $urandom_range(1, 4);
                    for (int n = 0; n < nin; n++)
                    begin
                        if ($urandom_range(9) == 0)
                            w = infl_w($urandom_range(mvs_pkg::MAX_BONES_DEF - 1), 1'b0,
                                       rand_weight(), rand_coord(), rand_coord(),
                                       rand_coord(), rand_coord(), n == nin - 1);
                        else
                            w = infl_w(pick_bone(), 1'b1, rand_weight(), rand_coord(),
                                       rand_coord(), rand_coord(), rand_coord(), n == nin - 1);
                        send_plain(w);
                    end
                end
            end
        end

        // drain and report
        settle();
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
